// ===== rtl/bitrd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and sizes for the MSB-first bit reader.
// No dependencies; every other file of the block imports this package.
package bitrd_pkg;

   localparam int BUFFER_BYTES  = 4096;
   localparam int MAX_READ_BITS = 64;
   localparam int RAM_AW        = $clog2(BUFFER_BYTES);
   localparam int INDEX_W       = 13;
   localparam int POS_W         = INDEX_W + 3;
   localparam int VALUE_W       = 64;
   localparam int COUNT_W       = 7;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 80;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LOAD  = 2'd0;
   localparam kind_type KIND_SEEK  = 2'd1;
   localparam kind_type KIND_READ  = 2'd2;
   localparam kind_type KIND_ALIGN = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_WIDTH   = 2'd1;
   localparam status_type STATUS_OVERRUN = 2'd2;

   typedef struct packed {
      kind_type             kind;
      logic [11:0]          load_address;
      logic [7:0]           load_byte;
      logic [14:0]          seek_position;
      logic [COUNT_W-1:0]   bit_count;
   } item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   field_value;
      logic [INDEX_W-1:0]   byte_position;
      status_type           status;
   } result_type;

   typedef struct packed {
      logic                 wr_en;
      logic [RAM_AW-1:0]    wr_addr;
      logic [7:0]           wr_data;
      logic                 rd_en;
      logic [RAM_AW-1:0]    rd_addr;
   } ram_req_type;

endpackage

// ===== rtl/bitrd_byte_ram.sv =====
`timescale 1ns / 1ps
// Byte-wide buffer memory of the bit reader: one write and one read port,
// registered read data. Depends on bitrd_pkg.
module bitrd_byte_ram import bitrd_pkg::*; (
   input  logic        clock,
   input  ram_req_type ram_req,
   output logic [7:0]  rd_data
);

   logic [7:0] byte_mem_ff [BUFFER_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         byte_mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= byte_mem_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bitrd_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the bit reader: position registers, byte-by-byte field
// assembly from the buffer memory, and the result register. Depends on bitrd_pkg.
module bitrd_ctrl import bitrd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  item_type            item,
   input  logic [INDEX_W-1:0]  data_length,
   output logic                result_valid,
   input  logic                result_ready,
   output result_type          result,
   output ram_req_type         ram_req,
   input  logic [7:0]          ram_rd_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_READ, ST_DONE} state_type;

   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [2:0]         off_ff, off_in;
   logic [RAM_AW-1:0]  rd_addr_ff, rd_addr_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [2:0]         cur_off_ff, cur_off_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]   next_pos_ff, next_pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               out_free;
   logic [INDEX_W-1:0] end_byte;
   logic [POS_W-1:0]   avail;
   logic [INDEX_W-1:0] idx_plus;
   logic [3:0]         byte_left;
   logic [3:0]         take;
   logic [7:0]         byte_al;
   logic [7:0]         bits;

   always_comb begin
      out_free = !rsp_valid_ff || result_ready;

      end_byte = (data_length > INDEX_W'(BUFFER_BYTES)) ? INDEX_W'(BUFFER_BYTES)
                                                        : data_length;
      if (idx_ff < end_byte) begin
         avail = POS_W'({end_byte - idx_ff, 3'b000}) - POS_W'(off_ff);
      end else begin
         avail = '0;
      end
      idx_plus = idx_ff + INDEX_W'(1);

      // Bits still unread in the current byte, and how many of them this byte gives.
      byte_left = 4'd8 - {1'b0, cur_off_ff};
      take      = (rem_ff < COUNT_W'(byte_left)) ? rem_ff[3:0] : byte_left;
      byte_al   = ram_rd_data << cur_off_ff;
      bits      = byte_al >> (4'd8 - take);

      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      rd_addr_in   = rd_addr_ff;
      rem_in       = rem_ff;
      cur_off_in   = cur_off_ff;
      value_in     = value_ff;
      next_pos_in  = next_pos_ff;
      rsp_valid_in = rsp_valid_ff && !result_ready;
      rsp_in       = rsp_ff;
      ram_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (item_ff.kind)
               KIND_LOAD: begin
                  if (out_free) begin
                     ram_req.wr_en   = int'(item_ff.load_address) < BUFFER_BYTES;
                     ram_req.wr_addr = RAM_AW'(item_ff.load_address);
                     ram_req.wr_data = item_ff.load_byte;
                     rsp_valid_in    = 1'b1;
                     rsp_in          = '{field_value: '0, byte_position: idx_ff,
                                         status: STATUS_OK};
                     state_in        = ST_IDLE;
                  end
               end
               KIND_SEEK: begin
                  if (out_free) begin
                     idx_in       = INDEX_W'(item_ff.seek_position[14:3]);
                     off_in       = item_ff.seek_position[2:0];
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{field_value: '0,
                                      byte_position: INDEX_W'(item_ff.seek_position[14:3]),
                                      status: STATUS_OK};
                     state_in     = ST_IDLE;
                  end
               end
               KIND_ALIGN: begin
                  if (out_free) begin
                     if (off_ff != 3'd0) begin
                        idx_in = idx_plus;
                        off_in = 3'd0;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{field_value: '0,
                                      byte_position: (off_ff != 3'd0) ? idx_plus : idx_ff,
                                      status: STATUS_OK};
                     state_in     = ST_IDLE;
                  end
               end
               KIND_READ: begin
                  if (int'(item_ff.bit_count) > MAX_READ_BITS) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{field_value: '0, byte_position: idx_ff,
                                         status: STATUS_WIDTH};
                        state_in     = ST_IDLE;
                     end
                  end else if (POS_W'(item_ff.bit_count) > avail) begin
                     // Overrun: jump to the end unless already at or past it.
                     if (out_free) begin
                        if (idx_ff < end_byte) begin
                           idx_in = end_byte;
                           off_in = 3'd0;
                        end
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{field_value: '0,
                                         byte_position: (idx_ff < end_byte) ? end_byte : idx_ff,
                                         status: STATUS_OVERRUN};
                        state_in     = ST_IDLE;
                     end
                  end else if (item_ff.bit_count == '0) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{field_value: '0, byte_position: idx_ff,
                                         status: STATUS_OK};
                        state_in     = ST_IDLE;
                     end
                  end else begin
                     ram_req.rd_en = 1'b1;
                     ram_req.rd_addr = idx_ff[RAM_AW-1:0];
                     rd_addr_in  = idx_ff[RAM_AW-1:0] + RAM_AW'(1);
                     rem_in      = item_ff.bit_count;
                     cur_off_in  = off_ff;
                     value_in    = '0;
                     next_pos_in = {idx_ff, off_ff} + POS_W'(item_ff.bit_count);
                     state_in    = ST_READ;
                  end
               end
            endcase
         end
         ST_READ: begin
            value_in   = (value_ff << take) | VALUE_W'(bits);
            rem_in     = rem_ff - COUNT_W'(take);
            cur_off_in = 3'd0;
            if (rem_in != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = rd_addr_ff;
               rd_addr_in      = rd_addr_ff + RAM_AW'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               idx_in       = next_pos_ff[POS_W-1:3];
               off_in       = next_pos_ff[2:0];
               rsp_valid_in = 1'b1;
               rsp_in       = '{field_value: value_ff,
                                byte_position: next_pos_ff[POS_W-1:3],
                                status: STATUS_OK};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rd_addr_ff  <= rd_addr_in;
      rem_ff      <= rem_in;
      cur_off_ff  <= cur_off_in;
      value_ff    <= value_in;
      next_pos_ff <= next_pos_in;
      rsp_ff      <= rsp_in;
   end

   assign item_ready   = (state_ff == ST_IDLE);
   assign result_valid = rsp_valid_ff;
   assign result       = rsp_ff;

endmodule

// ===== rtl/msb_first_bit_reader_core.sv =====
`timescale 1ns / 1ps
// MSB-first bit reader over a 4096-byte buffer. It works on one item at a time; a
// read that spans k bytes (k = 1 to 9) fetches them one by one through the single
// byte-wide read port of the buffer. The result is registered and is valid in
// the cycle after the item's last working cycle.
// Synchronous active-high reset clears position, length and handshakes; the
// buffer contents are not cleared and are defined only where loaded.
module msb_first_bit_reader_core import bitrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [11:0] load_address, [19:12] load_byte, [34:20] seek_position,
   // [41:35] bit_count, [47:42] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] field_value, [76:64] byte_position, [79:77] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [INDEX_W-1:0]    csr_data
);

   // The data_length register. Writes are taken in any cycle; the user must only
   // write it while no item is in flight, which the block itself does not enforce.
   logic [INDEX_W-1:0] data_length_ff, data_length_in;

   item_type    item;
   result_type  result;
   ram_req_type ram_req;
   logic [7:0]  ram_rd_data;

   always_comb begin
      data_length_in = data_length_ff;
      if (csr_valid) begin
         data_length_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_length_ff <= '0;
      end else begin
         data_length_ff <= data_length_in;
      end
   end

   assign csr_ready = 1'b1;

   // Unpack the request transfer into the item fields.
   assign item.kind          = req_tuser;
   assign item.load_address  = req_tdata[11:0];
   assign item.load_byte     = req_tdata[19:12];
   assign item.seek_position = req_tdata[34:20];
   assign item.bit_count     = req_tdata[41:35];

   bitrd_byte_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   bitrd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_tvalid),
      .item_ready   (req_tready),
      .item         (item),
      .data_length  (data_length_ff),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result),
      .ram_req      (ram_req),
      .ram_rd_data  (ram_rd_data)
   );

   assign rsp_tdata = {3'b000, result.byte_position, result.field_value};
   assign rsp_tuser = result.status;

endmodule

// ===== rtl/bitrd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the bit reader, bound to msb_first_bit_reader_core.
// Depends on bitrd_pkg and the top level's port list.
module bitrd_checker import bitrd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only one item is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   // A failed read carries no bits.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[VALUE_W-1:0] == '0)
      else $error("error result with nonzero value");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind msb_first_bit_reader_core bitrd_checker u_bitrd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
